// ===== rtl/core/modular_multiplier_core_macros.svh =====
// Assertion macros for the modular multiplier core.
// Included by the modules that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef MODULAR_MULTIPLIER_CORE_MACROS_SVH
`define MODULAR_MULTIPLIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MODMUL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modmul assertion failed");

// Next-cycle implication, disabled during reset
`define MODMUL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modmul assertion failed");

`endif

// ===== rtl/core/modmul_pkg.sv =====
// Shared constants, control structs and modular add helpers for the modular multiplier.
// No dependencies; imported by the interfaces and modules of the core.
package modmul_pkg;

	// Port field width and internal datapath width
	localparam int FIELD_BITS   = 64;
	localparam int OPERAND_BITS = 64;
	localparam int CNT_BITS     = $clog2(OPERAND_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(OPERAND_BITS - 1);

	typedef logic [OPERAND_BITS-1:0] word_t;
	typedef logic [OPERAND_BITS:0]   wide_t;

	// Control for the bit-serial reduction units
	typedef struct packed {
		logic load;
		logic step;
	} red_ctl_t;

	// Control for the add-and-double unit
	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

	// Subtract the modulus once if the value reaches it; value below twice the modulus
	function automatic word_t sub_if_ge(wide_t t, word_t m);
		wide_t mw;
		wide_t d;
		mw = {1'b0, m};
		d  = t - mw;
		return (t >= mw) ? d[OPERAND_BITS-1:0] : t[OPERAND_BITS-1:0];
	endfunction

	// (x + y) mod m for x, y below m
	function automatic word_t add_mod(word_t x, word_t y, word_t m);
		wide_t s;
		s = {1'b0, x} + {1'b0, y};
		return sub_if_ge(s, m);
	endfunction

endpackage

// ===== rtl/core/modmul_in_if.sv =====
// Operand channel of the modular multiplier: valid, ready and the three input fields.
// Depends on modmul_pkg for the field width.
interface modmul_in_if import modmul_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] multiplicand;
	logic [FIELD_BITS-1:0] multiplier;
	logic [FIELD_BITS-1:0] modulus;

	modport source (output valid, output multiplicand, output multiplier, output modulus,
		input ready);
	modport sink (input valid, input multiplicand, input multiplier, input modulus,
		output ready);
endinterface

// ===== rtl/core/modmul_out_if.sv =====
// Result channel of the modular multiplier: valid, ready, product and error flag.
// Depends on modmul_pkg for the field width.
interface modmul_out_if import modmul_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] product;
	logic                  zero_modulus;

	modport source (output valid, output product, output zero_modulus, input ready);
	modport sink (input valid, input product, input zero_modulus, output ready);
endinterface

// ===== rtl/core/modular_multiplier_core.sv =====
// Modular multiplier core: one operand beat in, one result beat out. Each item runs these
// steps in order: two bit-serial remainder units reduce both factors side by side, a load
// state, the add-and-double unit, and a write of the result register. A zero modulus skips
// the arithmetic and returns product 0 with zero_modulus set. The result register lets a
// new operand beat be taken while the previous result waits. Only the low OPERAND_BITS
// bits of each input field are used.
`include "modular_multiplier_core_macros.svh"

module modular_multiplier_core import modmul_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	modmul_in_if.sink   operands,
	modmul_out_if.source result
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_PREP   = 5'b00100,
		ST_MULT   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                err_q;
	word_t               mod_q;
	logic                out_valid_q;
	logic [FIELD_BITS-1:0] product_q;
	logic                zero_q;

	red_ctl_t red_ctl;
	mul_ctl_t mul_ctl;
	word_t    rem_a;
	word_t    rem_b;
	word_t    acc;
	word_t    dbl;
	logic     in_beat;
	logic     out_free;
	logic     out_load;
	word_t    in_mod;

	assign in_mod   = operands.modulus[OPERAND_BITS-1:0];
	assign in_beat  = operands.valid && operands.ready;
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_FINISH) && out_free;
	assign operands.ready = (state_q == ST_IDLE);

	// Drive the datapath units from the state
	always_comb begin
		red_ctl.load = in_beat && (in_mod != '0);
		red_ctl.step = (state_q == ST_REDUCE);
		mul_ctl.load = (state_q == ST_PREP);
		mul_ctl.step = (state_q == ST_MULT);
	end

	modmul_reduce u_red_a (
		.clk     (clk),
		.ctl     (red_ctl),
		.value   (operands.multiplicand[OPERAND_BITS-1:0]),
		.modulus (mod_q),
		.rem     (rem_a)
	);

	modmul_reduce u_red_b (
		.clk     (clk),
		.ctl     (red_ctl),
		.value   (operands.multiplier[OPERAND_BITS-1:0]),
		.modulus (mod_q),
		.rem     (rem_b)
	);

	modmul_addbl u_addbl (
		.clk     (clk),
		.ctl     (mul_ctl),
		.a_in    (rem_a),
		.b_in    (rem_b),
		.modulus (mod_q),
		.acc     (acc),
		.dbl     (dbl)
	);

	// Sequence the item: reduce, load, add-and-double, write result; a zero modulus goes straight to the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						err_q <= (in_mod == '0);
						cnt_q <= CNT_LAST;
						state_q <= (in_mod == '0) ? ST_FINISH : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= CNT_LAST;
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the modulus for the whole item
	always_ff @(posedge clk) begin
		if (in_beat) begin
			mod_q <= in_mod;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product_q <= err_q ? '0 : FIELD_BITS'(acc);
			zero_q    <= err_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.product      = product_q;
	assign result.zero_modulus = zero_q;

	`MODMUL_ASSERT_NEXT(a_start_reduce, in_beat && (in_mod != '0), state_q == ST_REDUCE)
	`MODMUL_ASSERT_NOW(a_rem_below_mod, state_q == ST_PREP, (rem_a < mod_q) && (rem_b < mod_q))
	`MODMUL_ASSERT_NOW(a_mult_below_mod, state_q == ST_MULT, (acc < mod_q) && (dbl < mod_q))
	`MODMUL_ASSERT_NOW(a_err_zero, result.valid && result.zero_modulus, result.product == '0)
	`MODMUL_ASSERT_NEXT(a_finish_out, out_load, result.valid)

endmodule

// ===== rtl/core/modmul_reduce.sv =====
// Bit-serial remainder unit: shifts the operand in MSB first, one bit per step.
// Depends on modmul_pkg for widths, control struct and sub_if_ge.
module modmul_reduce import modmul_pkg::*; (
	input  logic     clk,
	input  red_ctl_t ctl,
	input  word_t    value,
	input  word_t    modulus,
	output word_t    rem
);

	word_t val_q;
	word_t rem_q;

	// Load the operand, or shift one bit into the remainder and reduce it
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= value;
			rem_q <= '0;
		end else if (ctl.step) begin
			val_q <= {val_q[OPERAND_BITS-2:0], 1'b0};
			rem_q <= sub_if_ge({rem_q, val_q[OPERAND_BITS-1]}, modulus);
		end
	end

	assign rem = rem_q;

endmodule

// ===== rtl/core/modmul_addbl.sv =====
// Add-and-double unit: scans the reduced multiplicand LSB first, one bit per step.
// Depends on modmul_pkg for widths, control struct and add_mod.
module modmul_addbl import modmul_pkg::*; (
	input  logic     clk,
	input  mul_ctl_t ctl,
	input  word_t    a_in,
	input  word_t    b_in,
	input  word_t    modulus,
	output word_t    acc,
	output word_t    dbl
);

	word_t a_q;
	word_t b_q;
	word_t acc_q;

	// Load reduced factors, or add the doubled multiplier for a set bit and double it
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q   <= a_in;
			b_q   <= b_in;
			acc_q <= '0;
		end else if (ctl.step) begin
			a_q <= {1'b0, a_q[OPERAND_BITS-1:1]};
			b_q <= add_mod(b_q, b_q, modulus);
			if (a_q[0]) begin
				acc_q <= add_mod(acc_q, b_q, modulus);
			end
		end
	end

	assign acc = acc_q;
	assign dbl = b_q;

endmodule

// ===== test/modmul_product_checker.sv =====
// Checker for the modular multiplier: watches the operand and result channels,
// predicts each product and compares it with what the core returns.
// Depends on modmul_pkg and the two channel interfaces.
module modmul_product_checker import modmul_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	modmul_in_if        opnd,
	modmul_out_if       res,
	output int unsigned mismatch_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FIELD_BITS-1:0] product;
		logic                  zero_modulus;
	} product_beat_t;

	product_beat_t expected_products[$];

	// Work out a*b mod m on the low OPERAND_BITS bits, using a double-width product
	function automatic product_beat_t modular_product(logic [FIELD_BITS-1:0] a,
		logic [FIELD_BITS-1:0] b, logic [FIELD_BITS-1:0] m);
		word_t                     mod_w;
		word_t                     a_red;
		word_t                     b_red;
		logic [2*OPERAND_BITS-1:0] full;
		product_beat_t             r;
		r     = '0;
		mod_w = m[OPERAND_BITS-1:0];
		if (mod_w == '0) begin
			r.zero_modulus = 1'b1;
		end else begin
			a_red = a[OPERAND_BITS-1:0] % mod_w;
			b_red = b[OPERAND_BITS-1:0] % mod_w;
			full  = {{OPERAND_BITS{1'b0}}, a_red} * {{OPERAND_BITS{1'b0}}, b_red};
			full  = full % {{OPERAND_BITS{1'b0}}, mod_w};
			r.product[OPERAND_BITS-1:0] = full[OPERAND_BITS-1:0];
		end
		return r;
	endfunction

	// Queue a prediction per operand beat, check each result beat against the oldest
	always @(posedge clk) begin
		product_beat_t want;
		product_beat_t got;
		if (!arst_n) begin
			// Clear the counts while in reset
			mismatch_count <= 0;
			outstanding    <= 0;
		end else begin
			if (opnd.valid && opnd.ready)
				expected_products.push_back(modular_product(opnd.multiplicand,
					opnd.multiplier, opnd.modulus));
			if (res.valid && res.ready) begin
				got.product      = res.product;
				got.zero_modulus = res.zero_modulus;
				if (expected_products.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result beat with nothing pending: product %h flag %b",
							$realtime, got.product, got.zero_modulus);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_products.pop_front();
					if (got.product !== want.product || got.zero_modulus !== want.zero_modulus)
					begin
						if (mismatch_count < 10)
							$display("%0t: product exp %h got %h, zero_modulus exp %b got %b",
								$realtime, want.product, got.product, want.zero_modulus,
								got.zero_modulus);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			outstanding <= expected_products.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the modular multiplier testbench: clock, reset, operand stimulus and result
// back-pressure; prediction and comparison live in modmul_product_checker.
// Depends on modmul_pkg, the channel interfaces and modular_multiplier_core.
module tb_top;
	import modmul_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS  = 1950;
	localparam int unsigned DRAIN_EVERY   = 650;
	localparam int unsigned HOLD_CYCLES   = 800;
	localparam int unsigned SETTLE_CYCLES = 4 * OPERAND_BITS;
	localparam int unsigned CYCLE_LIMIT   = 1_500_000;
	localparam logic [FIELD_BITS-1:0] ALL_ONES = '1;
	localparam logic [FIELD_BITS-1:0] TOP_BIT  = {1'b1, {(FIELD_BITS-1){1'b0}}};

	logic        clk;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;

	modmul_in_if  opnd();
	modmul_out_if res();

	modular_multiplier_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (opnd),
		.result   (res)
	);

	modmul_product_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.opnd           (opnd),
		.res            (res),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one operand beat and hold it until the core takes it
	task automatic offer(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
		input logic [FIELD_BITS-1:0] m);
		opnd.valid        <= 1'b1;
		opnd.multiplicand <= a;
		opnd.multiplier   <= b;
		opnd.modulus      <= m;
		do @(posedge clk); while (!opnd.ready);
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic drain();
		opnd.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// Random word biased towards short, near-full and power-of-two values
	function automatic logic [FIELD_BITS-1:0] shaped_word();
		logic [FIELD_BITS-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: w = w >> $urandom_range(1, FIELD_BITS - 1);
			1: w = ~(w >> $urandom_range(1, FIELD_BITS - 1));
			2: w = 64'd1 << $urandom_range(0, FIELD_BITS - 1);
			3: w = (64'd1 << $urandom_range(1, FIELD_BITS - 1)) - 64'd1;
			default: ;
		endcase
		return w;
	endfunction

	// Factor: mostly arbitrary, sometimes already reduced or equal to the modulus
	function automatic logic [FIELD_BITS-1:0] pick_factor(logic [FIELD_BITS-1:0] m);
		logic [FIELD_BITS-1:0] w;
		w = shaped_word();
		case ($urandom_range(0, 19))
			0: w = m;
			1, 2, 3, 4, 5: if (m != '0) w = w % m;
			default: ;
		endcase
		return w;
	endfunction

	// Receiver: stall on a changing pattern, with two long hold-offs to fill the core
	initial begin
		int unsigned           taken;
		int unsigned           phase;
		logic [15:0]           pattern;
		bit                    early_hold_done;
		bit                    late_hold_done;
		taken           = 0;
		phase           = 0;
		pattern         = '1;
		early_hold_done = 1'b0;
		late_hold_done  = 1'b0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				taken++;
			if ((taken == 30 && !early_hold_done) || (taken == 1200 && !late_hold_done)) begin
				if (taken == 30)
					early_hold_done = 1'b1;
				else
					late_hold_done = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (phase[7:0] == 8'd0) begin
					case ($urandom_range(0, 3))
						0: pattern = '1;
						1: pattern = 16'($urandom);
						2: pattern = 16'($urandom | $urandom);
						default: pattern = 16'($urandom & $urandom);
					endcase
					pattern[0] = 1'b1;
				end
				res.ready <= pattern[phase[3:0]];
				phase++;
			end
		end
	end

	// Sender: reset, directed corners, then random bursts with gaps and drains
	initial begin
		int unsigned           sent;
		int unsigned           burst;
		logic [FIELD_BITS-1:0] m;
		arst_n            <= 1'b0;
		opnd.valid        <= 1'b0;
		opnd.multiplicand <= '0;
		opnd.multiplier   <= '0;
		opnd.modulus      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero modulus, modulus one, extremes of every field
		offer('0, '0, '0);
		offer(ALL_ONES, ALL_ONES, '0);
		offer(64'd5, 64'd7, 64'd1);
		offer(ALL_ONES, ALL_ONES, 64'd1);
		offer('0, '0, ALL_ONES);
		offer(ALL_ONES, ALL_ONES, ALL_ONES);
		offer(ALL_ONES - 1, ALL_ONES - 1, ALL_ONES);
		offer(64'd3, 64'd5, 64'd7);
		offer(TOP_BIT, 64'd2, ALL_ONES);
		offer(ALL_ONES, 64'd1, 64'd2);
		offer(64'd1000000007, 64'd12345, 64'd1000000007);
		offer(ALL_ONES - 1, ALL_ONES - 2, TOP_BIT);
		offer(TOP_BIT | 64'd1, TOP_BIT | 64'd1, TOP_BIT + 64'd1);
		offer(64'd123456789, 64'd987654321, 64'd1000000007);
		offer(64'd1, ALL_ONES, ALL_ONES - 64'd58);
		offer(ALL_ONES, '0, 64'd12345);
		offer(64'd2, TOP_BIT, TOP_BIT);
		offer(ALL_ONES, ALL_ONES, 64'd3);
		drain();

		// Random part
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				case ($urandom_range(0, 39))
					0: m = '0;
					1: m = 64'd1;
					2: m = 64'd2;
					default: m = shaped_word();
				endcase
				offer(pick_factor(m), pick_factor(m), m);
				sent++;
				if (sent % DRAIN_EVERY == 0)
					drain();
			end
			if ($urandom_range(0, 3) != 0) begin
				opnd.valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
